// ===== src/pdm_pkg.sv =====
// ----------------------------------------------------------------------------
// pdm_pkg: shared types and constants of the direction monotonicity unit
// Fixed field widths, register indexes, failure codes and the queue entry.
// ----------------------------------------------------------------------------
package pdm_pkg;

    // number formats
    localparam int WORD_W    = 32;
    localparam int PROJ_W    = 64;
    localparam int ACC_W     = 98;
    localparam int DIR_CNT   = 4;
    localparam int MAX_DIMS  = 4;
    localparam int FRAC_BITS = 16;
    localparam int SAT_W     = ACC_W - PROJ_W + 1;

    // number of terms that can enter the dot product
    localparam logic [2:0] DIM_LIMIT = (MAX_DIMS < DIR_CNT) ? 3'(MAX_DIMS) : 3'(DIR_CNT);

    // weight of a plain vertex
    localparam logic signed [WORD_W-1:0] WEIGHT_ONE = WORD_W'(1 << FRAC_BITS);

    // configuration register indexes
    localparam logic [2:0] CFG_RATIONAL_MODE = 3'd0;
    localparam logic [2:0] CFG_DIMS_USED     = 3'd1;
    localparam logic [2:0] CFG_DIR_X         = 3'd2;
    localparam logic [2:0] CFG_DIR_Y         = 3'd3;
    localparam logic [2:0] CFG_DIR_Z         = 3'd4;
    localparam logic [2:0] CFG_DIR_W         = 3'd5;

    // failure codes
    localparam logic [1:0] FAIL_NONE     = 2'd0;
    localparam logic [1:0] FAIL_DECREASE = 2'd1;
    localparam logic [1:0] FAIL_WEIGHT   = 2'd2;

    typedef logic signed [DIR_CNT-1:0][WORD_W-1:0] t_vec;

    // classified vertex as it sits in the queue
    typedef struct packed {
        t_vec                      coord;
        logic signed [WORD_W-1:0]  w_eff;
        logic                      w_zero;
        logic                      w_neg;
        logic                      rat;
        logic [2:0]                n_terms;
        logic                      last;
    } t_vtx;

    // head of the queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_vtx vtx;
    } t_head;

    // tag that travels with a registered product
    typedef struct packed {
        logic vld;
        logic sub;
        logic sh;
    } t_tag;

endpackage

// ===== src/pdm_front.sv =====
// ----------------------------------------------------------------------------
// pdm_front: vertex intake
// Accepts vertices, classifies weight and term count, and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pdm_front import pdm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rational_mode,
    input  logic [2:0]         i_dims_used,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_vec               i_coord,
    input  logic signed [31:0] i_weight,
    input  logic               i_last_vertex,
    output t_head              o_head,
    input  logic               i_pop
);

    t_vtx       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    t_vtx       w_cls;
    logic       w_push;

    // classify the incoming vertex
    always_comb begin
        w_cls.coord  = i_coord;
        w_cls.rat    = i_rational_mode;
        w_cls.w_eff  = i_rational_mode ? i_weight : WEIGHT_ONE;
        w_cls.w_zero = (w_cls.w_eff == '0);
        w_cls.w_neg  = w_cls.w_eff[WORD_W-1];
        w_cls.n_terms = (i_dims_used > DIM_LIMIT) ? DIM_LIMIT : i_dims_used;
        w_cls.last   = i_last_vertex;
    end

    assign o_stall = (r_count == 2'd2);
    assign w_push  = i_valid && !o_stall;

    // queue pointers
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, w_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cls;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.vtx   = r_q[r_rd_ptr];

endmodule

// ===== src/pdm_back.sv =====
// ----------------------------------------------------------------------------
// pdm_back: projection and ordering check
// Runs one vertex at a time through a shared multiplier: dot product terms,
// saturation, then the weighted cross products; keeps the polyline state and
// the result register.
// ----------------------------------------------------------------------------
module pdm_back import pdm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_vec       i_dir,
    input  t_head      i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_monotonic,
    output logic [1:0] o_failure_kind
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_START  = 4'd1;
    localparam logic [3:0] ST_DOT    = 4'd2;
    localparam logic [3:0] ST_DOTEND = 4'd3;
    localparam logic [3:0] ST_PROJ   = 4'd4;
    localparam logic [3:0] ST_CROSS  = 4'd5;
    localparam logic [3:0] ST_CREND  = 4'd6;
    localparam logic [3:0] ST_CMP    = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0]               r_state,  n_state;
    logic [1:0]               r_step,   n_step;
    t_vtx                     r_item,   n_item;
    logic signed [ACC_W-1:0]  r_acc,    n_acc;
    logic signed [PROJ_W-1:0] r_prod;
    t_tag                     r_tag,    n_tag;
    logic signed [PROJ_W-1:0] r_proj,   n_proj;
    logic signed [PROJ_W-1:0] r_pp,     n_pp;
    logic signed [WORD_W-1:0] r_pw,     n_pw;
    logic                     r_fwn,    n_fwn;
    logic                     r_first,  n_first;
    logic [1:0]               r_fail,   n_fail;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_mono,  n_out_mono;
    logic [1:0]               r_out_kind,  n_out_kind;

    logic signed [WORD_W:0]   w_mul_a;
    logic signed [WORD_W-1:0] w_mul_b;
    logic signed [WORD_W*2:0] w_mul_p;
    logic signed [ACC_W-1:0]  w_addend;
    logic signed [PROJ_W-1:0] w_sat;
    logic [SAT_W-1:0]         w_top;
    logic                     w_last_step;
    logic                     w_out_free;

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        n_tag   = '0;
        if (r_state == ST_DOT) begin
            w_mul_a = {i_dir[r_step][WORD_W-1], i_dir[r_step]};
            w_mul_b = r_item.coord[r_step];
            n_tag   = '{vld: 1'b1, sub: 1'b0, sh: 1'b0};
        end else if (r_state == ST_CROSS) begin
            // proj * prev weight minus prev proj * weight, in 32-bit halves
            case (r_step)
                2'd0: begin
                    w_mul_a = {1'b0, r_proj[31:0]};
                    w_mul_b = r_pw;
                    n_tag   = '{vld: 1'b1, sub: 1'b0, sh: 1'b0};
                end
                2'd1: begin
                    w_mul_a = {r_proj[63], r_proj[63:32]};
                    w_mul_b = r_pw;
                    n_tag   = '{vld: 1'b1, sub: 1'b0, sh: 1'b1};
                end
                2'd2: begin
                    w_mul_a = {1'b0, r_pp[31:0]};
                    w_mul_b = r_item.w_eff;
                    n_tag   = '{vld: 1'b1, sub: 1'b1, sh: 1'b0};
                end
                default: begin
                    w_mul_a = {r_pp[63], r_pp[63:32]};
                    w_mul_b = r_item.w_eff;
                    n_tag   = '{vld: 1'b1, sub: 1'b1, sh: 1'b1};
                end
            endcase
        end
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_p[PROJ_W-1:0];
    end

    // accumulate the registered product
    always_comb begin
        w_addend = {{(ACC_W-PROJ_W){r_prod[PROJ_W-1]}}, r_prod};
        if (r_tag.sh) begin
            w_addend = w_addend <<< WORD_W;
        end
    end

    // saturate the dot product to 64 bits
    always_comb begin
        w_top = r_acc[ACC_W-1:PROJ_W-1];
        if ((w_top == '0) || (w_top == '1)) begin
            w_sat = r_acc[PROJ_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            w_sat = {1'b1, {(PROJ_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(PROJ_W-1){1'b1}}};
        end
    end

    assign w_last_step = ({1'b0, r_step} == (r_item.n_terms - 3'd1));
    assign w_out_free  = !r_out_valid || !i_stall;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_item      = r_item;
        n_proj      = r_proj;
        n_pp        = r_pp;
        n_pw        = r_pw;
        n_fwn       = r_fwn;
        n_first     = r_first;
        n_fail      = r_fail;
        n_out_valid = r_out_valid && i_stall;
        n_out_mono  = r_out_mono;
        n_out_kind  = r_out_kind;
        o_pop       = 1'b0;
        if (r_tag.vld) begin
            n_acc = r_tag.sub ? (r_acc - w_addend) : (r_acc + w_addend);
        end else begin
            n_acc = r_acc;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    n_item  = i_head.vtx;
                    o_pop   = 1'b1;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_acc  = '0;
                n_step = 2'd0;
                if (r_fail != FAIL_NONE) begin
                    n_state = ST_DONE;
                end else if (r_item.rat && r_first && r_item.w_zero) begin
                    n_fail  = FAIL_WEIGHT;
                    n_first = 1'b0;
                    n_state = ST_DONE;
                end else if (r_item.rat && !r_first &&
                             (r_item.w_zero || (r_item.w_neg != r_fwn))) begin
                    n_fail  = FAIL_WEIGHT;
                    n_state = ST_DONE;
                end else if (r_item.n_terms == 3'd0) begin
                    n_state = ST_PROJ;
                end else begin
                    n_state = ST_DOT;
                end
            end
            ST_DOT: begin
                n_step = r_step + 2'd1;
                if (w_last_step) begin
                    n_state = ST_DOTEND;
                end
            end
            ST_DOTEND: begin
                n_state = ST_PROJ;
            end
            ST_PROJ: begin
                n_acc  = '0;
                n_step = 2'd0;
                if (r_first) begin
                    n_fwn   = r_item.w_neg;
                    n_pp    = w_sat;
                    n_pw    = r_item.w_eff;
                    n_first = 1'b0;
                    n_state = ST_DONE;
                end else if (!r_item.rat) begin
                    if (w_sat < r_pp) begin
                        n_fail = FAIL_DECREASE;
                    end else begin
                        n_pp = w_sat;
                        n_pw = r_item.w_eff;
                    end
                    n_state = ST_DONE;
                end else begin
                    n_proj  = w_sat;
                    n_state = ST_CROSS;
                end
            end
            ST_CROSS: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_state = ST_CREND;
                end
            end
            ST_CREND: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                // negative difference means the projection went down
                if (r_acc[ACC_W-1]) begin
                    n_fail = FAIL_DECREASE;
                end else begin
                    n_pp = r_proj;
                    n_pw = r_item.w_eff;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_item.last) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_mono  = (r_fail == FAIL_NONE);
                    n_out_kind  = r_fail;
                    n_pp        = '0;
                    n_pw        = '0;
                    n_fwn       = 1'b0;
                    n_first     = 1'b1;
                    n_fail      = FAIL_NONE;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and polyline state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tag       <= '0;
            r_pp        <= '0;
            r_pw        <= '0;
            r_fwn       <= 1'b0;
            r_first     <= 1'b1;
            r_fail      <= FAIL_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tag       <= n_tag;
            r_pp        <= n_pp;
            r_pw        <= n_pw;
            r_fwn       <= n_fwn;
            r_first     <= n_first;
            r_fail      <= n_fail;
            r_out_valid <= n_out_valid;
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_item     <= n_item;
        r_acc      <= n_acc;
        r_proj     <= n_proj;
        r_out_mono <= n_out_mono;
        r_out_kind <= n_out_kind;
    end

    assign o_valid        = r_out_valid;
    assign o_monotonic    = r_out_mono;
    assign o_failure_kind = r_out_kind;

endmodule

// ===== src/polyline_direction_monotonicity_unit.sv =====
// ----------------------------------------------------------------------------
// polyline_direction_monotonicity_unit: ordering check along a direction
// Checks that vertex projections onto the configured direction never go
// down over a polyline and reports a verdict on the last vertex.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  vertex   | i_valid / o_stall      | i_coord_x..w, i_weight, i_last_vertex
//  verdict  | o_valid / i_stall      | o_monotonic, o_failure_kind
//  config   | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  the back end runs one vertex at a time: a dot product of the n terms in use,
//  then cross products when a weighted vertex is compared; latched or weight
//  failures skip both; the single shared multiplier gives one product per cycle
//  a two-beat queue takes vertices while the back end works; o_stall when full
//  a verdict waits in the output register under i_stall, holding the back end
//  synchronous active-low reset clears the queue, sequencer and polyline state
// ----------------------------------------------------------------------------
module polyline_direction_monotonicity_unit import pdm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic signed [31:0] i_coord_w,
    input  logic signed [31:0] i_weight,
    input  logic               i_last_vertex,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_monotonic,
    output logic [1:0]         o_failure_kind
);

    logic       r_rational_mode;
    logic [2:0] r_dims_used;
    t_vec       r_dir;
    t_vec       w_coord;
    t_head      w_head;
    logic       w_pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rational_mode <= 1'b0;
            r_dims_used     <= 3'd3;
            r_dir           <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RATIONAL_MODE: r_rational_mode <= i_cfg_data[0];
                CFG_DIMS_USED:     r_dims_used     <= i_cfg_data[2:0];
                CFG_DIR_X:         r_dir[0]        <= i_cfg_data;
                CFG_DIR_Y:         r_dir[1]        <= i_cfg_data;
                CFG_DIR_Z:         r_dir[2]        <= i_cfg_data;
                CFG_DIR_W:         r_dir[3]        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_coord = {i_coord_w, i_coord_z, i_coord_y, i_coord_x};

    // intake and queue
    pdm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rational_mode (r_rational_mode),
        .i_dims_used     (r_dims_used),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_coord         (w_coord),
        .i_weight        (i_weight),
        .i_last_vertex   (i_last_vertex),
        .o_head          (w_head),
        .i_pop           (w_pop)
    );

    // projection and ordering check
    pdm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dir          (r_dir),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_monotonic    (o_monotonic),
        .o_failure_kind (o_failure_kind)
    );

endmodule

// ===== src/pdm_checker.sv =====
// ----------------------------------------------------------------------------
// pdm_checker: port-level checks of the monotonicity unit
// Watches the verdict channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module pdm_checker import pdm_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_monotonic,
    input logic [1:0] o_failure_kind
);

    // a held verdict beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_monotonic) && $stable(o_failure_kind))
        else $error("verdict changed while stalled");

    // the flag and the code agree
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_monotonic == (o_failure_kind == FAIL_NONE)))
        else $error("monotonic flag disagrees with failure kind");

    // only known failure codes leave the block
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_failure_kind == FAIL_NONE) || (o_failure_kind == FAIL_DECREASE) ||
                    (o_failure_kind == FAIL_WEIGHT))
        else $error("unknown failure kind");

    // no verdict right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("verdict valid after reset");

endmodule

bind polyline_direction_monotonicity_unit pdm_checker u_pdm_checker (.*);
